FILE: hdl/mbeq_pkg.sv
// Shared types and constants of the multiband graphic equalizer.
package mbeq_pkg;
	localparam int MaxBands   = 32;
	localparam int BandBits   = 5;
	localparam int SampleW    = 24;
	localparam int CoefW      = 32;
	localparam int CoefFrac   = 30;
	localparam int GainFrac   = 28;
	localparam int AccW       = 72;
	localparam logic signed [CoefW-1:0] GainReset = 32'sd170724950;

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_COEF  = 2'd1,
		OP_GAIN  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_MUL1, ST_MUL2, ST_SUM, ST_WB, ST_FIN, ST_OUT
	} state_t;

	localparam logic [0:0] REG_ENABLE = 1'b0;
	localparam logic [0:0] REG_BANDS  = 1'b1;

	// One control bundle from the sequencer to a channel lane.
	typedef struct packed {
		logic clear;
		logic start;
		logic mul1;
		logic mul2;
		logic sum;
		logic fin;
	} lane_ctl_t;

	function automatic logic signed [CoefW-1:0] sat32(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] hi;
		logic signed [AccW-1:0] lo;
		hi = AccW'(64'sh7fffffff);
		lo = -hi - AccW'(1);
		if (v > hi) return hi[CoefW-1:0];
		if (v < lo) return lo[CoefW-1:0];
		return v[CoefW-1:0];
	endfunction

	function automatic logic signed [SampleW-1:0] sat24(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] hi;
		logic signed [AccW-1:0] lo;
		hi = AccW'(64'sh7fffff);
		lo = -hi - AccW'(1);
		if (v > hi) return hi[SampleW-1:0];
		if (v < lo) return lo[SampleW-1:0];
		return v[SampleW-1:0];
	endfunction
endpackage

FILE: hdl/mbeq_lane.sv
// One channel lane: band recursion, delay storage and gain accumulation.
module mbeq_lane import mbeq_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctl_t                  ctl,
	input  logic [BandBits-1:0]        band,
	input  logic signed [SampleW-1:0]  x,
	input  logic signed [CoefW-1:0]    c1,
	input  logic signed [CoefW-1:0]    c2,
	input  logic signed [CoefW-1:0]    c3,
	input  logic signed [CoefW-1:0]    gain,
	output logic signed [SampleW-1:0]  y_out
);
	logic signed [CoefW-1:0]   y1_q [MaxBands];
	logic signed [CoefW-1:0]   y2_q [MaxBands];
	logic signed [SampleW-1:0] x1_q, x2_q;
	logic signed [63:0]        p3_q, p2_q, p1_q, pg_q;
	logic signed [AccW-1:0]    acc_q;
	logic signed [CoefW-1:0]   y_q;
	logic signed [SampleW:0]   dx;
	logic signed [AccW-1:0]    fsum;
	// mark whether pg_q holds a product not yet accumulated
	logic pg_valid_q;

	assign dx = {x[SampleW-1], x} - {x2_q[SampleW-1], x2_q};
	assign fsum = (AccW'(p3_q) + AccW'(p2_q) - AccW'(p1_q)) >>> CoefFrac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxBands; i++) begin
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
			x1_q  <= '0;
			x2_q  <= '0;
			p3_q  <= '0;
			p2_q  <= '0;
			p1_q  <= '0;
			pg_q  <= '0;
			acc_q <= '0;
			y_q   <= '0;
			y_out <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < MaxBands; i++) begin
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
			x1_q <= '0;
			x2_q <= '0;
		end else begin
			if (ctl.mul1) begin
				p3_q <= 64'(c3) * 64'(y1_q[band]);
				p2_q <= 64'(c2) * 64'(dx);
				p1_q <= 64'(c1) * 64'(y2_q[band]);
			end
			if (ctl.mul2) y_q <= sat32(fsum);
			if (ctl.sum) begin
				pg_q <= 64'(y_q) * 64'(gain);
				y2_q[band] <= y1_q[band];
				y1_q[band] <= y_q;
			end
			if (ctl.start && !ctl.mul1) acc_q <= '0;
			else if (ctl.mul1 && pg_valid_q) acc_q <= acc_q + AccW'(pg_q);
			if (ctl.fin) begin
				y_out <= sat24((acc_q + AccW'(pg_q)) >>> GainFrac);
				x2_q <= x1_q;
				x1_q <= x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pg_valid_q <= 1'b0;
		else if (ctl.start || ctl.fin || ctl.clear) pg_valid_q <= 1'b0;
		else if (ctl.sum) pg_valid_q <= 1'b1;
		else if (ctl.mul1) pg_valid_q <= 1'b0;
	end
endmodule

FILE: hdl/mbeq_tables.sv
// Coefficient and gain storage with registered band read.
module mbeq_tables import mbeq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     coef_we,
	input  logic                     gain_we,
	input  logic [BandBits-1:0]      wr_band,
	input  logic [1:0]               wr_sel,
	input  logic signed [CoefW-1:0]  wr_value,
	input  logic [BandBits-1:0]      rd_band,
	output logic signed [CoefW-1:0]  c1,
	output logic signed [CoefW-1:0]  c2,
	output logic signed [CoefW-1:0]  c3,
	output logic signed [CoefW-1:0]  gain
);
	logic signed [CoefW-1:0] c_q [3][MaxBands];
	logic signed [CoefW-1:0] g_q [MaxBands];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxBands; i++) begin
				c_q[0][i] <= '0;
				c_q[1][i] <= '0;
				c_q[2][i] <= '0;
				g_q[i]    <= GainReset;
			end
		end else begin
			if (coef_we && wr_sel != 2'd3) c_q[wr_sel][wr_band] <= wr_value;
			if (gain_we) g_q[wr_band] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		c1   <= c_q[0][rd_band];
		c2   <= c_q[1][rd_band];
		c3   <= c_q[2][rd_band];
		gain <= g_q[rd_band];
	end
endmodule

FILE: hdl/multiband_iir_graphic_equalizer.sv
// Top level of the multiband graphic equalizer.
// Usage:
//  s_axis: tdata {right_in, left_in, table_value, coef_select, band_index}
//  low bit first, tuser = operation. Frames and table writes share one stream.
//  m_axis: tdata {right_out, left_out}, one item per process-frame item.
//  cfg: index 0 enable, 1 band_count, written while the block is idle.
//  Throughput: one item at a time. A filtered frame steps through ST_RD, then
//  ST_MUL1, ST_MUL2, ST_SUM (and ST_WB between bands), ST_FIN and ST_OUT; both
//  channels run in two lanes in parallel, each band passes through read,
//  multiply, saturate and gain steps of the shared sequencer.
//  A bypass frame goes from acceptance through ST_OUT to the output register;
//  a table write leaves the input ready for the next item.
//  Reset clears history, coefficients, registers; gains become 0.636.
//  A stalled receiver holds the result in the output register; the input
//  side accepts again once the result is taken.
module multiband_iir_graphic_equalizer import mbeq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata, // band_index, coef_select, table_value, left_in, right_in
	input  logic [1:0]  s_axis_tuser, // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata, // left_out, right_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	state_t state_q, state_d;
	logic enable_q;
	logic [BandBits-1:0] nb_q, band_q;
	logic signed [SampleW-1:0] l_q, r_q;
	logic bypass_q;
	logic signed [CoefW-1:0] c1, c2, c3, gain;
	logic signed [SampleW-1:0] ly, ry;
	lane_ctl_t ctl;
	logic acc, clr, last;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign clr = (acc && op_t'(s_axis_tuser) == OP_CLEAR) ||
		(cfg_valid && cfg_index == REG_ENABLE && cfg_data[0] && !enable_q);
	assign last = band_q == nb_q - BandBits'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			nb_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ENABLE) enable_q <= cfg_data[0];
			else nb_q <= cfg_data[BandBits-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc && op_t'(s_axis_tuser) == OP_FRAME)
				state_d = (!enable_q || nb_q == '0) ? ST_OUT : ST_RD;
			ST_RD:   state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_SUM;
			ST_SUM:  state_d = last ? ST_FIN : ST_WB;
			ST_WB:   state_d = ST_MUL1;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.clear = clr;
		ctl.start = state_q == ST_RD;
		ctl.mul1  = state_q == ST_MUL1;
		ctl.mul2  = state_q == ST_MUL2;
		ctl.sum   = state_q == ST_SUM;
		ctl.fin   = state_q == ST_FIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			band_q <= '0;
			m_axis_tvalid <= 1'b0;
			bypass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if (state_q == ST_IDLE && acc) begin
				band_q <= '0;
				bypass_q <= !enable_q || nb_q == '0;
			end
			if (state_q == ST_SUM && !last) band_q <= band_q + BandBits'(1);
			if (state_q == ST_OUT) m_axis_tvalid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			l_q <= s_axis_tdata[62:39];
			r_q <= s_axis_tdata[86:63];
		end
		if (state_q == ST_OUT)
			m_axis_tdata <= bypass_q ? {r_q, l_q} : {ry, ly};
	end

	// band_q advances in ST_SUM; ST_WB lets the registered read settle before ST_MUL1
	mbeq_tables u_tab (
		.clk, .arst_n,
		.coef_we(acc && op_t'(s_axis_tuser) == OP_COEF),
		.gain_we(acc && op_t'(s_axis_tuser) == OP_GAIN),
		.wr_band(s_axis_tdata[4:0]), .wr_sel(s_axis_tdata[6:5]),
		.wr_value(s_axis_tdata[38:7]), .rd_band(band_q),
		.c1, .c2, .c3, .gain
	);

	mbeq_lane u_left (.clk, .arst_n, .ctl, .band(band_q), .x(l_q),
		.c1, .c2, .c3, .gain, .y_out(ly));
	mbeq_lane u_right (.clk, .arst_n, .ctl, .band(band_q), .x(r_q),
		.c1, .c2, .c3, .gain, .y_out(ry));
endmodule

FILE: hdl/mbeq_checker.sv
// Port-level checks of the equalizer, bound to the top level.
module mbeq_checker import mbeq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	// a frame item occupies the block; table writes do not
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && op_t'(s_axis_tuser) == OP_FRAME |=> !s_axis_tready)
		else $error("input taken while frame in flight");
endmodule

bind multiband_iir_graphic_equalizer mbeq_checker u_chk (.*);
